// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file mavg_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mavg_pkg.sv =====
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared widths, constants and the level encoder of the moving average meter.
// ----------------------------------------------------------------------------
package mavg_pkg;

  localparam int WINDOW_DEFAULT = 16;
  localparam int SAMPLE_W       = 10;
  localparam int AVG_W          = 10;
  localparam int LEVEL_W        = 5;
  localparam int S_TDATA_W      = 16;
  localparam int M_TDATA_W      = 16;
  localparam int M_PAD_W        = M_TDATA_W - AVG_W - LEVEL_W;
  localparam int S_PAD_W        = S_TDATA_W - SAMPLE_W;
  localparam int AVG_MAX        = 1023;
  localparam int DIV_STEPS      = 3;

  localparam logic [AVG_W-1:0] LEVEL_B1 = AVG_W'(200);
  localparam logic [AVG_W-1:0] LEVEL_B2 = AVG_W'(400);
  localparam logic [AVG_W-1:0] LEVEL_B3 = AVG_W'(600);
  localparam logic [AVG_W-1:0] LEVEL_B4 = AVG_W'(800);

  localparam logic [LEVEL_W-1:0] LEVEL_1 = 5'h01;
  localparam logic [LEVEL_W-1:0] LEVEL_2 = 5'h02;
  localparam logic [LEVEL_W-1:0] LEVEL_3 = 5'h04;
  localparam logic [LEVEL_W-1:0] LEVEL_4 = 5'h08;
  localparam logic [LEVEL_W-1:0] LEVEL_5 = 5'h10;

  function automatic logic [LEVEL_W-1:0] level_code(input logic [AVG_W-1:0] avg);
    logic [LEVEL_W-1:0] code;
    if (avg <= LEVEL_B1) begin
      code = LEVEL_1;
    end else if (avg <= LEVEL_B2) begin
      code = LEVEL_2;
    end else if (avg <= LEVEL_B3) begin
      code = LEVEL_3;
    end else if (avg <= LEVEL_B4) begin
      code = LEVEL_4;
    end else begin
      code = LEVEL_5;
    end
    return code;
  endfunction

endpackage

// ===== rtl/mavg_cell.sv =====
// ----------------------------------------------------------------------------
// mavg_cell
// One sample slot of the history line; passes its sample on at each shift.
// ----------------------------------------------------------------------------
module mavg_cell #(
  parameter int WIDTH = mavg_pkg::SAMPLE_W
) (
  input  logic             clk,
  input  logic             shift_en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] slot;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      slot <= din;
    end
  end

  assign dout = slot;

endmodule

// ===== rtl/mavg_divider.sv =====
// ----------------------------------------------------------------------------
// mavg_divider
// Iterative restoring divider, STEPS quotient bits per cycle.
// ----------------------------------------------------------------------------
module mavg_divider #(
  parameter int SUM_W  = 14,
  parameter int DEN_W  = 5,
  parameter int QUOT_W = mavg_pkg::AVG_W,
  parameter int STEPS  = mavg_pkg::DIV_STEPS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [DEN_W-1:0]  divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quotient
);

  localparam int CYCLES = (QUOT_W + STEPS - 1) / STEPS;
  localparam int TOT_W  = CYCLES * STEPS;
  localparam int DSH_W  = SUM_W + DEN_W + TOT_W;
  localparam int CNT_W  = $clog2(CYCLES + 1);

  logic [DSH_W-1:0] rem;
  logic [DSH_W-1:0] dsh;
  logic [TOT_W-1:0] quot;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [DSH_W-1:0] rem_w;
  logic [DSH_W-1:0] dsh_w;
  logic [TOT_W-1:0] quot_w;

  // quotient is known to fit, so the divisor starts shifted to the top bit
  always_comb begin
    rem_w  = rem;
    dsh_w  = dsh;
    quot_w = quot;
    for (int k = 0; k < STEPS; k++) begin
      if (rem_w >= dsh_w) begin
        rem_w  = rem_w - dsh_w;
        quot_w = {quot_w[TOT_W-2:0], 1'b1};
      end else begin
        quot_w = {quot_w[TOT_W-2:0], 1'b0};
      end
      dsh_w = dsh_w >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem  <= DSH_W'(dividend);
      dsh  <= DSH_W'(divisor) << (TOT_W - 1);
      quot <= '0;
      cnt  <= CNT_W'(CYCLES);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      rem  <= rem_w;
      dsh  <= dsh_w;
      quot <= quot_w;
      cnt  <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient = quot[QUOT_W-1:0];

endmodule

// ===== rtl/moving_average_level_meter.sv =====
// ----------------------------------------------------------------------------
// moving_average_level_meter
// Moving average of converter samples with a one-hot level indication.
// ----------------------------------------------------------------------------
// Each sample word yields one result word holding the truncated mean of the
// last WINDOW samples (fewer during warm-up) and a one-hot level code with
// bounds at 200, 400, 600 and 800. Samples shift through a row of WINDOW
// cells; the oldest one leaves the running sum once the row is full. The
// accept starts the divider, which resolves three quotient bits per cycle
// for the warm-up mean sum/count, and the output load ends the word; no new
// sample is taken before it. The full-window mean is a shift of the sum. An
// unread result waits in the output register while the next sample is taken.
// ----------------------------------------------------------------------------
module moving_average_level_meter #(
  parameter int WINDOW = mavg_pkg::WINDOW_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mavg_pkg::S_TDATA_W-1:0] s_tdata,  // [9:0] sample
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mavg_pkg::M_TDATA_W-1:0] m_tdata   // [9:0] average, [14:10] level
);

  localparam int SUM_W  = $clog2(WINDOW * mavg_pkg::AVG_MAX + 1);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SHIFT  = FILL_W - 1;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t state;

  logic [SUM_W-1:0]  sum;
  logic [FILL_W-1:0] fill;

  logic [mavg_pkg::SAMPLE_W-1:0] tap [WINDOW+1];
  logic [mavg_pkg::SAMPLE_W-1:0] sample;
  logic                          accept;
  logic                          full;
  logic                          out_load;
  logic [SUM_W-1:0]              sum_next;
  logic [FILL_W-1:0]             fill_next;
  logic [SUM_W-1:0]              avg_shift;
  logic [mavg_pkg::AVG_W-1:0]    avg_full;
  logic [mavg_pkg::AVG_W-1:0]    avg_sel;
  logic [mavg_pkg::AVG_W-1:0]    div_quot;
  logic                          div_done;

  assign sample   = s_tdata[mavg_pkg::SAMPLE_W-1:0];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign full     = (fill == FILL_W'(WINDOW));
  assign out_load = (state == ST_DIV) && div_done && (!m_tvalid || m_tready);

  assign tap[0] = sample;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    mavg_cell #(
      .WIDTH (mavg_pkg::SAMPLE_W)
    ) u_cell (
      .clk      (clk),
      .shift_en (accept),
      .din      (tap[i]),
      .dout     (tap[i+1])
    );
  end

  // the last cell holds the sample that drops out of a full window
  always_comb begin
    if (full) begin
      sum_next  = sum - SUM_W'(tap[WINDOW]) + SUM_W'(sample);
      fill_next = fill;
    end else begin
      sum_next  = sum + SUM_W'(sample);
      fill_next = fill + FILL_W'(1);
    end
  end

  mavg_divider #(
    .SUM_W  (SUM_W),
    .DEN_W  (FILL_W),
    .QUOT_W (mavg_pkg::AVG_W),
    .STEPS  (mavg_pkg::DIV_STEPS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (sum_next),
    .divisor  (fill_next),
    .done     (div_done),
    .quotient (div_quot)
  );

  // saturate for window sizes that are not a power of two
  always_comb begin
    avg_shift = sum >> SHIFT;
    if (avg_shift > SUM_W'(mavg_pkg::AVG_MAX)) begin
      avg_full = mavg_pkg::AVG_W'(mavg_pkg::AVG_MAX);
    end else begin
      avg_full = avg_shift[mavg_pkg::AVG_W-1:0];
    end
    avg_sel = full ? avg_full : div_quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      sum      <= '0;
      fill     <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {{mavg_pkg::M_PAD_W{1'b0}}, mavg_pkg::level_code(avg_sel), avg_sel};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            sum   <= sum_next;
            fill  <= fill_next;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/mavg_checker.sv =====
// ----------------------------------------------------------------------------
// mavg_checker
// Port-level checks of the moving average meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mavg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [mavg_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [mavg_pkg::M_TDATA_W-1:0] m_tdata
);

  logic [mavg_pkg::AVG_W-1:0]   avg_out;
  logic [mavg_pkg::LEVEL_W-1:0] lvl_out;
  logic [mavg_pkg::LEVEL_W-1:0] lvl_want;
  logic                         out_stall;

  assign avg_out   = m_tdata[mavg_pkg::AVG_W-1:0];
  assign lvl_out   = m_tdata[mavg_pkg::AVG_W+mavg_pkg::LEVEL_W-1:mavg_pkg::AVG_W];
  assign lvl_want  = mavg_pkg::level_code(avg_out);
  assign out_stall = m_tvalid && !m_tready;

  // level code must agree with the average it travels with
  `ASSERT_CLK(a_level_match, m_tvalid |-> (lvl_out == lvl_want), "level does not match average")

  // a word is worked on until its result is loaded, so no back-to-back accept
  `ASSERT_CLK(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "accept while busy")

  `ASSERT_CLK(a_out_hold, out_stall |=> (m_tvalid && $stable(m_tdata)), "stalled word changed")

  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> (!m_tvalid && s_tready), "result pending after reset")

  `ASSERT_CLK(a_sample_known, s_tvalid |-> !$isunknown(s_tdata), "sample word unknown")

endmodule

bind moving_average_level_meter mavg_checker u_mavg_checker (.*);
